[sv/lgs_pkg.sv]
// Shared constants and types for the lightmap luxel gamma shader.
package lgs_pkg;

  // Defaults for the top-level parameters
  localparam int STYLE_COUNT_DEF   = 4;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed geometry of the request and result fields
  localparam int MAX_STYLES    = 4;
  localparam int CHANNEL_COUNT = 3;
  localparam int BYTE_W        = 8;
  localparam int INDEX_W       = 8;
  localparam int TABLE_DEPTH   = 256;
  localparam int FIELD_W       = 17;
  localparam int SAMPLE_W      = 24;
  localparam int PRESENT_W     = 4;

  // Request kinds
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_SHADE = 1'b1
  } mode_t;

endpackage

[sv/lgs_if.sv]
// Valid/ready channel interfaces for shade requests and shaded results.
interface lgs_in_if import lgs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [INDEX_W-1:0]   table_index;
  logic [FIELD_W-1:0]   table_value;
  logic [PRESENT_W-1:0] style_present;
  logic [SAMPLE_W-1:0]  sample_style0;
  logic [SAMPLE_W-1:0]  sample_style1;
  logic [SAMPLE_W-1:0]  sample_style2;
  logic [SAMPLE_W-1:0]  sample_style3;

  modport source (
    output valid, mode, table_index, table_value, style_present,
    output sample_style0, sample_style1, sample_style2, sample_style3,
    input  ready
  );
  modport sink (
    input  valid, mode, table_index, table_value, style_present,
    input  sample_style0, sample_style1, sample_style2, sample_style3,
    output ready
  );
endinterface

interface lgs_out_if import lgs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] red_level;
  logic [FIELD_W-1:0] green_level;
  logic [FIELD_W-1:0] blue_level;

  modport source (
    output valid, red_level, green_level, blue_level,
    input  ready
  );
  modport sink (
    input  valid, red_level, green_level, blue_level,
    output ready
  );
endinterface

[sv/lgs_lane.sv]
// One lookup lane: a private copy of the gamma table with a registered read.
module lgs_lane import lgs_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [INDEX_W-1:0]       wr_addr,
  input  logic [FRACTION_BITS:0]   wr_data,
  input  logic                     rd_en,
  input  logic                     rd_use,
  input  logic [INDEX_W-1:0]       rd_addr,
  output logic [FRACTION_BITS:0]   rd_data
);

  localparam int LW = FRACTION_BITS + 1;
  localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [LW-1:0] mem [TABLE_DEPTH];

  // Table write, broadcast to every lane by the top level
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; an absent style contributes 1.0
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rd_use ? mem[rd_addr] : LEVEL_ONE;
    end
  end

endmodule

[sv/lgs_merge.sv]
// Merge pipeline: per channel, multiplies the lane factors one style per stage.
module lgs_merge import lgs_pkg::*; #(
  parameter int STYLE_COUNT   = STYLE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FRACTION_BITS:0] factor [STYLE_COUNT][CHANNEL_COUNT],
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FRACTION_BITS:0] level [CHANNEL_COUNT]
);

  localparam int LW = FRACTION_BITS + 1;
  localparam int PW = 2 * LW;
  localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // vld[0]: lane read stage; vld[k+1]: after the style k multiply
  logic [STYLE_COUNT:0] vld;
  logic [STYLE_COUNT:0] adv;

  logic [LW-1:0] lvl [STYLE_COUNT][CHANNEL_COUNT];
  logic [LW-1:0] fac [STYLE_COUNT][STYLE_COUNT][CHANNEL_COUNT];

  // A stage loads when it is empty or its successor moves on
  always_comb begin
    adv[STYLE_COUNT] = !vld[STYLE_COUNT] || out_ready;
    for (int i = STYLE_COUNT - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i <= STYLE_COUNT; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // One truncating Q1.F multiply per channel per stage
  for (genvar k = 0; k < STYLE_COUNT; k++) begin : g_stage
    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
      logic [LW-1:0] prev;
      logic [LW-1:0] mult;
      logic [PW-1:0] prod;

      if (k == 0) begin : g_first
        assign prev = LEVEL_ONE;
        assign mult = factor[0][c];
      end else begin : g_next
        assign prev = lvl[k-1][c];
        assign mult = fac[k-1][k][c];
      end

      assign prod = PW'(prev) * PW'(mult);

      always_ff @(posedge clk) begin
        if (adv[k+1]) begin
          lvl[k][c] <= LW'(prod >> FRACTION_BITS);
        end
      end

      // Carry the factors of later styles down the pipe
      for (genvar s = k + 1; s < STYLE_COUNT; s++) begin : g_carry
        if (k == 0) begin : g_first
          always_ff @(posedge clk) begin
            if (adv[k+1]) begin
              fac[k][s][c] <= factor[s][c];
            end
          end
        end else begin : g_next
          always_ff @(posedge clk) begin
            if (adv[k+1]) begin
              fac[k][s][c] <= fac[k-1][s][c];
            end
          end
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[STYLE_COUNT];
  assign level     = lvl[STYLE_COUNT-1];

endmodule

[sv/lightmap_luxel_gamma_shade.sv]
// Top level of the lightmap luxel gamma shader.
//
// Input channel luxel_in carries two kinds of request. A load request
// (mode 0) writes table_value, saturated to 1.0, into gamma entry
// table_index and gives no result. A shade request (mode 1) looks up every
// channel byte of each present style and multiplies the looked-up values per
// channel in unsigned Q1.F fixed point, starting from 1.0, truncating each
// product. Every entry read must have been loaded since reset.
// Output channel shade_out gives red, green and blue levels of one luxel.
//
// One request is taken per cycle while luxel_in.ready is high. A shade
// result passes the table read, which registers at the accepting edge, and
// then the multiply stage of each style in turn before it is offered. Each of the
// STYLE_COUNT x 3 lanes owns a copy of the table so all bytes are read at once.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// stops taking requests only once all STYLE_COUNT + 1 stages hold a request.
// Reset empties the pipeline; the table contents are kept and must be loaded.
module lightmap_luxel_gamma_shade import lgs_pkg::*; #(
  parameter int STYLE_COUNT   = STYLE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lgs_in_if.sink    luxel_in,
  lgs_out_if.source shade_out
);

  localparam int LW = FRACTION_BITS + 1;
  localparam int CW = (FIELD_W > LW) ? FIELD_W : LW;
  localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                 pipe_ready;
  logic                 load_wr;
  logic                 shade_valid;
  logic [CW-1:0]        value_wide;
  logic [LW-1:0]        value_sat;
  logic [SAMPLE_W-1:0]  sample [MAX_STYLES];
  logic [LW-1:0]        factor [STYLE_COUNT][CHANNEL_COUNT];
  logic [LW-1:0]        level  [CHANNEL_COUNT];

  // Request decode
  assign luxel_in.ready = pipe_ready;
  assign load_wr     = luxel_in.valid && pipe_ready && (luxel_in.mode == MODE_LOAD);
  assign shade_valid = luxel_in.valid && (luxel_in.mode == MODE_SHADE);

  // Clamp table entries to 1.0 on write
  assign value_wide = CW'(luxel_in.table_value);
  assign value_sat  = (value_wide > CW'(LEVEL_ONE)) ? LEVEL_ONE : LW'(value_wide);

  assign sample[0] = luxel_in.sample_style0;
  assign sample[1] = luxel_in.sample_style1;
  assign sample[2] = luxel_in.sample_style2;
  assign sample[3] = luxel_in.sample_style3;

  // Lookup lanes, one per style and channel
  for (genvar s = 0; s < STYLE_COUNT; s++) begin : g_style
    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_chan
      lgs_lane #(
        .FRACTION_BITS (FRACTION_BITS)
      ) u_lane (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (luxel_in.table_index),
        .wr_data (value_sat),
        .rd_en   (pipe_ready),
        .rd_use  (luxel_in.style_present[s]),
        .rd_addr (sample[s][c*BYTE_W +: BYTE_W]),
        .rd_data (factor[s][c])
      );
    end
  end

  // Multiply chain and output register
  lgs_merge #(
    .STYLE_COUNT   (STYLE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (shade_valid),
    .in_ready  (pipe_ready),
    .factor    (factor),
    .out_valid (shade_out.valid),
    .out_ready (shade_out.ready),
    .level     (level)
  );

  assign shade_out.red_level   = FIELD_W'(level[0]);
  assign shade_out.green_level = FIELD_W'(level[1]);
  assign shade_out.blue_level  = FIELD_W'(level[2]);

endmodule
